/* rtl/olt_pkg.sv */
// ----------------------------------------------------------------------------
// olt_pkg: shared types, codes and helpers for the order lifecycle table
// Entry layout, channel payloads, operation/status/state codes and the
// legal-move table used by the controller and the counter unit.
// ----------------------------------------------------------------------------
package olt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SCAN_W      = IDX_W + 1;
   localparam int CNT_W       = 7;

   // operation codes
   localparam logic [2:0] FUNC_REGISTER   = 3'd0;
   localparam logic [2:0] FUNC_TRANSITION = 3'd1;
   localparam logic [2:0] FUNC_FILL       = 3'd2;
   localparam logic [2:0] FUNC_PURGE      = 3'd3;
   localparam logic [2:0] FUNC_QUERY      = 3'd4;

   // status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_DUPLICATE = 3'd2;
   localparam logic [2:0] STAT_ILLEGAL   = 3'd3;
   localparam logic [2:0] STAT_FULL      = 3'd4;

   // order lifecycle states
   localparam logic [3:0] ST_NEW        = 4'd0;
   localparam logic [3:0] ST_PENDACK    = 4'd1;
   localparam logic [3:0] ST_RESTING    = 4'd2;
   localparam logic [3:0] ST_PARTFILL   = 4'd3;
   localparam logic [3:0] ST_PENDCANCEL = 4'd4;
   localparam logic [3:0] ST_PENDMODIFY = 4'd5;
   localparam logic [3:0] ST_FILLED     = 4'd6;
   localparam logic [3:0] ST_CANCELLED  = 4'd7;
   localparam logic [3:0] ST_REJECTED   = 4'd8;
   localparam logic [3:0] ST_LAST       = ST_REJECTED;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] order_id;
      logic [3:0]  target_state;
      logic [31:0] quantity;
   } olt_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [3:0]       order_state;
      logic [31:0]      remaining_qty;
      logic [31:0]      filled_qty;
      logic [CNT_W-1:0] active_total;
      logic [CNT_W-1:0] pending_ack_total;
      logic [CNT_W-1:0] resting_total;
      logic [CNT_W-1:0] purged_total;
   } olt_rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [3:0]  state;
      logic [31:0] remaining;
      logic [31:0] filled;
   } olt_entry_type;

   // one state change of one entry, for the counter unit
   typedef struct packed {
      logic       en;
      logic       has_old;
      logic [3:0] old_state;
      logic [3:0] target_state;
   } olt_cnt_upd_type;

   typedef struct packed {
      logic [CNT_W-1:0] active;
      logic [CNT_W-1:0] pending;
      logic [CNT_W-1:0] resting;
   } olt_cnt_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_FINISH
   } olt_fsm_type;

   function automatic logic is_final(input logic [3:0] s);
      return (s == ST_FILLED) || (s == ST_CANCELLED) || (s == ST_REJECTED);
   endfunction

   function automatic logic is_pending(input logic [3:0] s);
      return s == ST_PENDACK;
   endfunction

   function automatic logic is_resting(input logic [3:0] s);
      return (s == ST_RESTING) || (s == ST_PARTFILL);
   endfunction

   // bit t set: move to t is legal
   function automatic logic [15:0] legal_mask(input logic [3:0] from);
      logic [15:0] m;
      m = '0;
      case (from)
         ST_NEW: begin
            m[ST_PENDACK] = 1'b1;
            m[ST_REJECTED] = 1'b1;
         end
         ST_PENDACK: begin
            m[ST_RESTING] = 1'b1;  m[ST_PARTFILL] = 1'b1;  m[ST_FILLED] = 1'b1;
            m[ST_REJECTED] = 1'b1; m[ST_CANCELLED] = 1'b1;
         end
         ST_RESTING, ST_PARTFILL: begin
            m[ST_PARTFILL] = 1'b1;   m[ST_FILLED] = 1'b1;   m[ST_PENDCANCEL] = 1'b1;
            m[ST_PENDMODIFY] = 1'b1; m[ST_CANCELLED] = 1'b1;
         end
         ST_PENDCANCEL: begin
            m[ST_CANCELLED] = 1'b1; m[ST_FILLED] = 1'b1;
            m[ST_RESTING] = 1'b1;   m[ST_PARTFILL] = 1'b1;
         end
         ST_PENDMODIFY: begin
            m[ST_RESTING] = 1'b1; m[ST_PARTFILL] = 1'b1;
            m[ST_FILLED] = 1'b1;  m[ST_CANCELLED] = 1'b1;
         end
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic move_ok(input logic [3:0] from, input logic [3:0] to);
      logic [15:0] m;
      m = legal_mask(from);
      if ((to > ST_LAST) || (from > ST_LAST)) return 1'b0;
      if (from == to) return 1'b1;
      return m[to];
   endfunction

endpackage

/* rtl/olt_ram.sv */
// ----------------------------------------------------------------------------
// olt_ram: single-port-write, single-port-read synchronous RAM
// Registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module olt_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 100,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/olt_counts.sv */
// ----------------------------------------------------------------------------
// olt_counts: running active / pending-ack / resting totals
// Adjusted by one entry's old and new state per update; purged entries are
// terminal and never counted, so a purge needs no update.
// ----------------------------------------------------------------------------
module olt_counts (
   input  logic                    clock,
   input  logic                    reset,
   input  olt_pkg::olt_cnt_upd_type upd,
   output olt_pkg::olt_cnt_type     cnt
);
   import olt_pkg::*;

   olt_cnt_type cnt_ff;
   olt_cnt_type cnt_in;
   logic        old_act, old_pnd, old_rst;
   logic        new_act, new_pnd, new_rst;

   assign old_act = upd.has_old && !is_final(upd.old_state);
   assign old_pnd = upd.has_old && is_pending(upd.old_state);
   assign old_rst = upd.has_old && is_resting(upd.old_state);
   assign new_act = !is_final(upd.target_state);
   assign new_pnd = is_pending(upd.target_state);
   assign new_rst = is_resting(upd.target_state);

   always_comb begin
      cnt_in = cnt_ff;
      if (upd.en) begin
         cnt_in.active  = cnt_ff.active + CNT_W'(new_act) - CNT_W'(old_act);
         cnt_in.pending = cnt_ff.pending + CNT_W'(new_pnd) - CNT_W'(old_pnd);
         cnt_in.resting = cnt_ff.resting + CNT_W'(new_rst) - CNT_W'(old_rst);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt = cnt_ff;

endmodule

/* rtl/order_lifecycle_table.sv */
// ----------------------------------------------------------------------------
// order_lifecycle_table: table of tracked orders with lifecycle checks
// Register, transition, fill, purge and query on a table of orders kept in
// one synchronous entry memory; lookup is a linear scan of the table.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_stall | olt_req_type
//   rsp     | out | rsp_valid/rsp_stall | olt_rsp_type
//
// One item at a time. A lookup that hits slot k ends its scan at that slot;
// a miss, a register of a new id and a purge scan all TABLE_DEPTH entries.
// The scan is paced by the entry memory's single read port, one entry a cycle.
// Reset clears the valid bits and totals directly; no clearing pass.
// A new item is taken while the previous result waits under rsp_stall.
// ----------------------------------------------------------------------------
module order_lifecycle_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  olt_pkg::olt_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output olt_pkg::olt_rsp_type rsp_payload
);
   import olt_pkg::*;

   olt_fsm_type            state_ff, state_in;
   olt_req_type            req_ff, req_in;
   logic [SCAN_W-1:0]      scan_ff, scan_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]       purged_ff, purged_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   olt_rsp_type            res_ff, res_in;
   olt_rsp_type            rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   olt_entry_type          rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   olt_entry_type          wr_data;
   olt_cnt_upd_type        upd;
   olt_cnt_type            cnt;

   logic                   lookup_op;
   logic                   chk_live;
   logic                   hit;
   logic                   purge_hit;
   logic                   issue;
   logic                   over_fill;
   logic [31:0]            fill_amt;
   logic [31:0]            fill_rem;
   logic [31:0]            fill_done;
   logic [3:0]             fill_state;

   olt_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH ($bits(olt_entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   olt_counts u_counts (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .cnt   (cnt)
   );

   assign lookup_op = (req_ff.func == FUNC_REGISTER) || (req_ff.func == FUNC_TRANSITION) ||
                      (req_ff.func == FUNC_FILL) || (req_ff.func == FUNC_QUERY);
   assign chk_live  = chk_valid_ff && valid_ff[chk_idx_ff];
   assign hit       = chk_live && (rd_data.id == req_ff.order_id);
   assign purge_hit = chk_live && is_final(rd_data.state);
   assign issue     = scan_ff < SCAN_W'(TABLE_DEPTH);

   // fill clipped to what remains
   assign over_fill  = req_ff.quantity > rd_data.remaining;
   assign fill_amt   = over_fill ? rd_data.remaining : req_ff.quantity;
   assign fill_rem   = rd_data.remaining - fill_amt;
   assign fill_done  = rd_data.filled + fill_amt;
   assign fill_state = (fill_rem == 32'd0) ? ST_FILLED : ST_PARTFILL;

   assign rd_addr = scan_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      purged_in     = purged_ff;
      valid_in      = valid_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = match_idx_ff;
      wr_data       = rd_data;
      upd           = '0;
      req_stall     = 1'b1;

      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in        = req_payload;
               scan_in       = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               purged_in     = '0;
               state_in      = (req_payload.func <= FUNC_QUERY) ? FSM_SCAN : FSM_DECIDE;
            end
         end

         // reads issue one entry a cycle; the check lags by the read latency
         FSM_SCAN: begin
            if (lookup_op && hit) begin
               found_in     = 1'b1;
               match_idx_in = chk_idx_ff;
               state_in     = FSM_DECIDE;
            end else begin
               if ((req_ff.func == FUNC_PURGE) && purge_hit) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  purged_in            = purged_ff + CNT_W'(1);
               end
               if (chk_valid_ff && !valid_ff[chk_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
               if (issue) begin
                  rd_en        = 1'b1;
                  chk_valid_in = 1'b1;
                  chk_idx_in   = scan_ff[IDX_W-1:0];
                  scan_in      = scan_ff + SCAN_W'(1);
               end else if (!chk_valid_ff) begin
                  state_in = FSM_DECIDE;
               end
            end
         end

         // rd_data still holds the matched entry here
         FSM_DECIDE: begin
            res_in   = '0;
            state_in = FSM_FINISH;
            case (req_ff.func)
               FUNC_REGISTER: begin
                  if (found_ff) begin
                     res_in.status        = STAT_DUPLICATE;
                     res_in.order_state   = rd_data.state;
                     res_in.remaining_qty = rd_data.remaining;
                     res_in.filled_qty    = rd_data.filled;
                  end else if (req_ff.target_state > ST_LAST) begin
                     res_in.status = STAT_ILLEGAL;
                  end else if (!free_found_ff) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     wr_en                 = 1'b1;
                     wr_addr               = free_idx_ff;
                     wr_data.id            = req_ff.order_id;
                     wr_data.state         = req_ff.target_state;
                     wr_data.remaining     = req_ff.quantity;
                     wr_data.filled        = 32'd0;
                     valid_in[free_idx_ff] = 1'b1;
                     upd.en                = 1'b1;
                     upd.target_state      = req_ff.target_state;
                     res_in.order_state    = req_ff.target_state;
                     res_in.remaining_qty  = req_ff.quantity;
                  end
               end
               FUNC_TRANSITION: begin
                  if (!found_ff) begin
                     res_in.status = STAT_NOT_FOUND;
                  end else begin
                     res_in.order_state   = rd_data.state;
                     res_in.remaining_qty = rd_data.remaining;
                     res_in.filled_qty    = rd_data.filled;
                     if (!move_ok(rd_data.state, req_ff.target_state)) begin
                        res_in.status = STAT_ILLEGAL;
                     end else begin
                        wr_en              = 1'b1;
                        wr_data.state      = req_ff.target_state;
                        upd.en             = 1'b1;
                        upd.has_old        = 1'b1;
                        upd.old_state      = rd_data.state;
                        upd.target_state   = req_ff.target_state;
                        res_in.order_state = req_ff.target_state;
                     end
                  end
               end
               FUNC_FILL: begin
                  if (!found_ff) begin
                     res_in.status = STAT_NOT_FOUND;
                  end else begin
                     wr_en                = 1'b1;
                     wr_data.state        = fill_state;
                     wr_data.remaining    = fill_rem;
                     wr_data.filled       = fill_done;
                     upd.en               = 1'b1;
                     upd.has_old          = 1'b1;
                     upd.old_state        = rd_data.state;
                     upd.target_state     = fill_state;
                     res_in.order_state   = fill_state;
                     res_in.remaining_qty = fill_rem;
                     res_in.filled_qty    = fill_done;
                  end
               end
               FUNC_PURGE: begin
                  res_in.purged_total = purged_ff;
               end
               FUNC_QUERY: begin
                  if (!found_ff) begin
                     res_in.status = STAT_NOT_FOUND;
                  end else begin
                     res_in.order_state   = rd_data.state;
                     res_in.remaining_qty = rd_data.remaining;
                     res_in.filled_qty    = rd_data.filled;
                  end
               end
               default: res_in = '0;
            endcase
         end

         // totals were updated on the write edge and are current here
         FSM_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in                   = res_ff;
               rsp_in.active_total      = cnt.active;
               rsp_in.pending_ack_total = cnt.pending;
               rsp_in.resting_total     = cnt.resting;
               rsp_valid_in             = 1'b1;
               state_in                 = FSM_IDLE;
            end
         end

         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         valid_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      purged_ff     <= purged_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a new order never lands on an occupied slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DECIDE && wr_en && !found_ff) |-> !valid_ff[free_idx_ff])
      else $error("register writes an occupied slot");

   // updates of an existing order go back to the matched, still valid slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DECIDE && wr_en && found_ff) |->
         (valid_ff[match_idx_ff] && wr_addr == match_idx_ff))
      else $error("update addresses the wrong slot");

   // pending-ack and resting orders are disjoint subsets of the active ones
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cnt.pending} + {1'b0, cnt.resting}) <= {1'b0, cnt.active})
      else $error("order totals inconsistent");

   // a checked slot was read on the previous cycle
   assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> ($past(rd_en) && chk_idx_ff == $past(rd_addr)))
      else $error("check does not follow its read");

   assert property (@(posedge clock) disable iff (reset)
      scan_ff <= SCAN_W'(TABLE_DEPTH) || state_ff != FSM_SCAN)
      else $error("scan ran past the table");

endmodule

/* tb/order_lifecycle_table_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_lifecycle_table_check: predicts and checks order table results
// Watches both channels of the order table and keeps its own copy of the
// table. Each request transfer queues one expected result. Each result
// transfer is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module order_lifecycle_table_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  olt_pkg::olt_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  olt_pkg::olt_rsp_type rsp_payload,
   output int                   results_owed,
   output int                   fail_total
);
   import olt_pkg::*;

   logic        book_used  [TABLE_DEPTH];
   logic [31:0] book_id    [TABLE_DEPTH];
   logic [3:0]  book_state [TABLE_DEPTH];
   logic [31:0] book_left  [TABLE_DEPTH];
   logic [31:0] book_done  [TABLE_DEPTH];

   olt_rsp_type owed_q[$];
   int          failures = 0;

   function automatic logic terminal(input logic [3:0] s);
      return s inside {ST_FILLED, ST_CANCELLED, ST_REJECTED};
   endfunction

   function automatic logic move_allowed(input logic [3:0] src, input logic [3:0] dst);
      if ((src > ST_LAST) || (dst > ST_LAST)) return 1'b0;
      if (src == dst) return 1'b1;
      case (src)
         ST_NEW:        return dst inside {ST_PENDACK, ST_REJECTED};
         ST_PENDACK:    return dst inside {ST_RESTING, ST_PARTFILL, ST_FILLED,
                                           ST_REJECTED, ST_CANCELLED};
         ST_RESTING, ST_PARTFILL:
                        return dst inside {ST_PARTFILL, ST_FILLED, ST_PENDCANCEL,
                                           ST_PENDMODIFY, ST_CANCELLED};
         ST_PENDCANCEL: return dst inside {ST_CANCELLED, ST_FILLED, ST_RESTING,
                                           ST_PARTFILL};
         ST_PENDMODIFY: return dst inside {ST_RESTING, ST_PARTFILL, ST_FILLED,
                                           ST_CANCELLED};
         default:       return 1'b0;
      endcase
   endfunction

   function automatic int find_order(input logic [31:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (book_used[i] && (book_id[i] == id)) return i;
      return -1;
   endfunction

   task automatic apply_order_op(input olt_req_type op, output olt_rsp_type res);
      int          slot;
      logic [31:0] take;
      slot       = -1;
      res        = '0;
      res.status = STAT_OK;
      case (op.func)
         FUNC_REGISTER: begin
            slot = find_order(op.order_id);
            if (slot >= 0) begin
               res.status = STAT_DUPLICATE;
            end else if (op.target_state > ST_LAST) begin
               res.status = STAT_ILLEGAL;
            end else begin
               // lowest free slot wins
               for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                  if (!book_used[i]) slot = i;
               if (slot < 0) begin
                  res.status = STAT_FULL;
               end else begin
                  book_used[slot]  = 1'b1;
                  book_id[slot]    = op.order_id;
                  book_state[slot] = op.target_state;
                  book_left[slot]  = op.quantity;
                  book_done[slot]  = '0;
               end
            end
         end
         FUNC_TRANSITION: begin
            slot = find_order(op.order_id);
            if (slot < 0) res.status = STAT_NOT_FOUND;
            else if (!move_allowed(book_state[slot], op.target_state)) res.status = STAT_ILLEGAL;
            else book_state[slot] = op.target_state;
         end
         FUNC_FILL: begin
            slot = find_order(op.order_id);
            if (slot < 0) begin
               res.status = STAT_NOT_FOUND;
            end else begin
               // fill is clipped to what is left, whatever the state
               take = (op.quantity > book_left[slot]) ? book_left[slot] : op.quantity;
               book_done[slot]  = book_done[slot] + take;
               book_left[slot]  = book_left[slot] - take;
               book_state[slot] = (book_left[slot] == '0) ? ST_FILLED : ST_PARTFILL;
            end
         end
         FUNC_PURGE: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (book_used[i] && terminal(book_state[i])) begin
                  book_used[i]     = 1'b0;
                  res.purged_total = res.purged_total + 1'b1;
               end
         end
         FUNC_QUERY: begin
            slot = find_order(op.order_id);
            if (slot < 0) res.status = STAT_NOT_FOUND;
         end
         default: ;
      endcase
      if (slot >= 0) begin
         res.order_state   = book_state[slot];
         res.remaining_qty = book_left[slot];
         res.filled_qty    = book_done[slot];
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (book_used[i]) begin
            if (!terminal(book_state[i])) res.active_total = res.active_total + 1'b1;
            if (book_state[i] == ST_PENDACK) res.pending_ack_total = res.pending_ack_total + 1'b1;
            if (book_state[i] inside {ST_RESTING, ST_PARTFILL})
               res.resting_total = res.resting_total + 1'b1;
         end
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      olt_rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) book_used[i] = 1'b0;
         owed_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            apply_order_op(req_payload, want);
            owed_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               $display("%0t: result transfer with nothing expected: expected none, actual 0x%0h",
                        $time, rsp_payload);
               failures++;
            end else begin
               want = owed_q.pop_front();
               compare_field("status",            want.status,            rsp_payload.status);
               compare_field("order_state",       want.order_state,       rsp_payload.order_state);
               compare_field("remaining_qty",     want.remaining_qty,     rsp_payload.remaining_qty);
               compare_field("filled_qty",        want.filled_qty,        rsp_payload.filled_qty);
               compare_field("active_total",      want.active_total,      rsp_payload.active_total);
               compare_field("pending_ack_total", want.pending_ack_total,
                             rsp_payload.pending_ack_total);
               compare_field("resting_total",     want.resting_total,     rsp_payload.resting_total);
               compare_field("purged_total",      want.purged_total,      rsp_payload.purged_total);
            end
         end
      end
      results_owed <= owed_q.size();
      fail_total   <= failures;
   end

endmodule

/* tb/order_lifecycle_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_lifecycle_table_tb: top level testbench for the order table
// Drives a directed opening (empty table, duplicates, bad states, legal and
// illegal moves, clipped fills, purge, unused codes) and then random order
// traffic over a small id pool so that the table fills, with random idling
// on both channels and one long result hold-off. Checking is done by the
// checker instance; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module order_lifecycle_table_tb;
   import olt_pkg::*;

   localparam int RANDOM_ITEMS = 1900;
   localparam int POOL_SIZE    = 80;
   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   olt_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   olt_rsp_type rsp_payload;
   int          results_owed;
   int          fail_total;
   int          sent_items = 0;
   bit          calm = 1'b0;

   order_lifecycle_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   order_lifecycle_table_check table_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .results_owed (results_owed),
      .fail_total   (fail_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic olt_req_type order_op(input logic [2:0] func, input logic [31:0] id,
                                            input logic [3:0] state, input logic [31:0] qty);
      olt_req_type op;
      op.func         = func;
      op.order_id     = id;
      op.target_state = state;
      op.quantity     = qty;
      return op;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send(input olt_req_type op);
      while (!calm && ($urandom_range(0, 99) < 28)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   initial begin : result_side
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         // one long hold-off so the block backs up into the request side
         if (!held && (sent_items >= 500)) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 28);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      olt_req_type op;
      int          mix;
      int          pick;
      logic [31:0] id_pool [POOL_SIZE];
      req_valid   <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;
      mix         = 0;
      id_pool[0]  = '0;
      id_pool[1]  = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening on an empty table
      send(order_op(FUNC_QUERY,      32'h0000_0000, ST_NEW,        32'h0));
      send(order_op(FUNC_REGISTER,   32'h0000_0000, ST_NEW,        32'hFFFF_FFFF));
      send(order_op(FUNC_REGISTER,   32'h0000_0000, ST_PENDACK,    32'h5));
      send(order_op(FUNC_REGISTER,   32'hFFFF_FFFF, 4'hF,          32'h7));
      send(order_op(FUNC_REGISTER,   32'hFFFF_FFFF, ST_PENDACK,    32'h0));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_NEW,        32'h0));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_RESTING,    32'h0));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_PENDACK,    32'h0));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_LAST + 1'b1, 32'h0));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_RESTING,    32'h0));
      send(order_op(FUNC_FILL,       32'h0000_0000, ST_NEW,        32'h1));
      send(order_op(FUNC_FILL,       32'h0000_0000, ST_NEW,        32'hFFFF_FFFF));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_FILLED,     32'h0));
      send(order_op(FUNC_TRANSITION, 32'h0000_0000, ST_RESTING,    32'h0));
      send(order_op(FUNC_FILL,       32'hFFFF_FFFF, ST_NEW,        32'h5));
      send(order_op(FUNC_FILL,       32'h0000_007B, ST_NEW,        32'h5));
      send(order_op(FUNC_TRANSITION, 32'h0000_007B, ST_PENDACK,    32'h0));
      send(order_op(FUNC_REGISTER,   32'h5555_5555, ST_CANCELLED,  32'hAAAA_AAAA));
      send(order_op(FUNC_REGISTER,   32'hAAAA_AAAA, ST_REJECTED,   32'h5555_5555));
      send(order_op(FUNC_REGISTER,   32'h1234_5678, ST_PENDMODIFY, 32'h10));
      send(order_op(FUNC_TRANSITION, 32'h1234_5678, ST_PENDCANCEL, 32'h0));
      send(order_op(FUNC_PURGE,      32'h0000_0000, ST_NEW,        32'h0));
      send(order_op(FUNC_QUERY,      32'h0000_0000, ST_NEW,        32'h0));
      send(order_op(FUNC_QUERY,      32'h1234_5678, ST_NEW,        32'h0));
      send(order_op(FUNC_QUERY + 3'd1, 32'h1234_5678, ST_FILLED,   32'h1));
      send(order_op(FUNC_QUERY + 3'd3, 32'h1234_5678, ST_NEW,      32'h0));
      send(order_op(FUNC_PURGE,      32'h0000_0000, ST_NEW,        32'h0));

      // random traffic in blocks: table building, lifecycle moves, noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ((n % 64) == 0) mix = $urandom_range(0, 9);
         calm = (n >= 900) && (n < 1200);
         pick = $urandom_range(0, 99);
         if (mix >= 8) begin
            op.func = 3'($urandom);
         end else if (mix <= 2) begin
            op.func = (pick < 60) ? FUNC_REGISTER : (pick < 78) ? FUNC_TRANSITION :
                      (pick < 88) ? FUNC_FILL     : (pick < 98) ? FUNC_QUERY : FUNC_PURGE;
         end else if (pick < 3) begin
            op.func = 3'(FUNC_QUERY + $urandom_range(1, 3));
         end else begin
            op.func = (pick < 18) ? FUNC_REGISTER : (pick < 60) ? FUNC_TRANSITION :
                      (pick < 80) ? FUNC_FILL     : (pick < 94) ? FUNC_QUERY : FUNC_PURGE;
         end
         op.order_id     = ((mix >= 8) || ($urandom_range(0, 99) < 8)) ?
                           $urandom : id_pool[$urandom_range(0, POOL_SIZE - 1)];
         op.target_state = ((mix >= 8) || ($urandom_range(0, 99) < 8)) ?
                           4'($urandom) : 4'($urandom_range(0, ST_LAST));
         case ($urandom_range(0, 9))
            0:       op.quantity = '0;
            1:       op.quantity = '1;
            2, 3:    op.quantity = $urandom;
            default: op.quantity = $urandom_range(1, 40);
         endcase
         send(op);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (fail_total == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
